@@ sv/blt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blt_pkg
// Shared types, constants and the character class table of the BASIC line
// tokenizer.
// ----------------------------------------------------------------------------
package blt_pkg;

    localparam int CHAR_W = 8;
    localparam int KIND_W = 3;

    // Character class bits.
    localparam logic [4:0] CL_ALPHA = 5'h01;
    localparam logic [4:0] CL_DIGIT = 5'h02;
    localparam logic [4:0] CL_SPACE = 5'h04;
    localparam logic [4:0] CL_COMP  = 5'h08;
    localparam logic [4:0] CL_ARITH = 5'h10;

    // Characters compared on all eight bits.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_APOS   = 8'h27;

    // Token kinds as seen on the output.
    localparam logic [KIND_W-1:0] KIND_IDENT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STRING = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd5;

    // Scan modes; a token mode carries the code of its token kind.
    typedef enum logic [2:0] {
        MODE_IDENT   = 3'd0,
        MODE_NUMBER  = 3'd1,
        MODE_COMP    = 3'd2,
        MODE_ARITH   = 3'd3,
        MODE_STRING  = 3'd4,
        MODE_IDLE    = 3'd5,
        MODE_COMMENT = 3'd6
    } mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] tok_char;
        logic [KIND_W-1:0] tok_kind;
        logic              tok_last;
        logic              line_end;
        logic              unterminated;
    } result_t;

    function automatic logic [4:0] char_class(input logic [6:0] c);
        logic [4:0] cls;
        case (c) inside
            7'd8, 7'd9, 7'd13, 7'd26, 7'd29, 7'd32:      cls = CL_SPACE;
            7'd33, 7'd37, 7'd38, 7'd42, 7'd43, 7'd45, 7'd47: cls = CL_ARITH;
            [7'd48:7'd57]:                               cls = CL_DIGIT;
            [7'd60:7'd62]:                               cls = CL_COMP;
            [7'd65:7'd90], 7'd95, [7'd97:7'd122]:        cls = CL_ALPHA;
            default:                                     cls = 5'h00;
        endcase
        return cls;
    endfunction

endpackage

@@ sv/blt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blt_char_if / blt_tok_if
// Valid/ready channels for source characters and token words.
// ----------------------------------------------------------------------------
interface blt_char_if;
    logic                         valid;
    logic                         ready;
    logic [blt_pkg::CHAR_W-1:0]   in_char;

    modport source (output valid, output in_char, input ready);
    modport sink   (input valid, input in_char, output ready);
endinterface

interface blt_tok_if;
    logic                         valid;
    logic                         ready;
    logic [blt_pkg::CHAR_W-1:0]   tok_char;
    logic [blt_pkg::KIND_W-1:0]   tok_kind;
    logic                         tok_last;
    logic                         line_end;
    logic                         unterminated;

    modport source (output valid, output tok_char, output tok_kind, output tok_last,
                    output line_end, output unterminated, input ready);
    modport sink   (input valid, input tok_char, input tok_kind, input tok_last,
                    input line_end, input unterminated, output ready);
endinterface

@@ sv/basic_line_tokenizer.sv @@
`timescale 1ns / 1ps
// The first word produced by a character is written to the result queue and is on the
// output in the cycle after it is taken when no earlier word is still waiting there.
// Throughput: one character per cycle while each yields at most one word and the output
// takes every word; a character that yields two words (token end plus line end or plus a
// single-character word, identifier plus dollar, string close) queues both for the output.
// Reset: scan mode returns to idle (skipping whitespace) and the result queue empties.
// ----------------------------------------------------------------------------
// basic_line_tokenizer
// Streaming tokenizer of one BASIC source line, one character per word in and
// one token character or line end per word out.
// ----------------------------------------------------------------------------
module basic_line_tokenizer
(
    input  logic       clk,
    input  logic       rst_n,
    blt_char_if.sink   chars,
    blt_tok_if.source  tokens
);

    blt_pkg::mode_t                scan_mode_reg, scan_mode_next;
    logic [blt_pkg::CHAR_W-1:0]    held_char_reg, held_char_next;

    // Four-entry result queue; a character is taken only while two slots are free.
    blt_pkg::result_t              queue_reg [4];
    logic [1:0]                    wr_ptr_reg;
    logic [1:0]                    rd_ptr_reg;
    logic [2:0]                    count_reg;

    logic                          accept;
    logic                          pop;
    logic [1:0]                    n_res;
    blt_pkg::result_t              res0, res1;

    logic [blt_pkg::CHAR_W-1:0]    c;
    logic [4:0]                    cls;
    logic                          is_end;
    logic                          run_cont;
    logic                          to_idle_scan;

    assign chars.ready = (count_reg <= 3'd2);
    assign accept      = chars.valid && chars.ready;
    assign pop         = tokens.valid && tokens.ready;

    assign c      = chars.in_char;
    assign cls    = blt_pkg::char_class(c[6:0]);
    assign is_end = (c == blt_pkg::CH_LF) || (c == blt_pkg::CH_NUL);

    always_comb
    begin
        case (scan_mode_reg)
            blt_pkg::MODE_IDENT:  run_cont = |(cls & (blt_pkg::CL_ALPHA | blt_pkg::CL_DIGIT));
            blt_pkg::MODE_NUMBER: run_cont = |(cls & blt_pkg::CL_DIGIT);
            blt_pkg::MODE_COMP:   run_cont = |(cls & blt_pkg::CL_COMP);
            default:              run_cont = |(cls & blt_pkg::CL_ARITH);
        endcase
    end

    always_comb
    begin
        blt_pkg::result_t le_res;
        blt_pkg::result_t held_res;
        blt_pkg::result_t start_res;
        logic             start_emit;
        blt_pkg::mode_t   start_mode;
        logic [1:0]       n_pre;

        le_res   = '{tok_char: '0, tok_kind: '0, tok_last: 1'b0,
                     line_end: 1'b1, unterminated: 1'b0};
        held_res = '{tok_char: held_char_reg, tok_kind: scan_mode_reg,
                     tok_last: 1'b0, line_end: 1'b0, unterminated: 1'b0};
        scan_mode_next = scan_mode_reg;
        held_char_next = held_char_reg;
        n_res          = 2'd0;
        res0           = le_res;
        res1           = le_res;
        to_idle_scan   = 1'b0;
        n_pre          = 2'd0;

        // Decision for a character seen from idle: start, skip, or emit alone.
        start_emit = 1'b0;
        start_res  = le_res;
        start_mode = blt_pkg::MODE_IDLE;
        if (is_end)
        begin
            start_emit = 1'b1;
        end
        else if ((cls & blt_pkg::CL_SPACE) != '0)
        begin
            start_mode = blt_pkg::MODE_IDLE;
        end
        else if (c == blt_pkg::CH_APOS)
        begin
            start_mode = blt_pkg::MODE_COMMENT;
        end
        else if ((cls & blt_pkg::CL_ALPHA) != '0)
        begin
            start_mode = blt_pkg::MODE_IDENT;
        end
        else if ((cls & blt_pkg::CL_DIGIT) != '0)
        begin
            start_mode = blt_pkg::MODE_NUMBER;
        end
        else if ((cls & blt_pkg::CL_COMP) != '0)
        begin
            start_mode = blt_pkg::MODE_COMP;
        end
        else if ((cls & blt_pkg::CL_ARITH) != '0)
        begin
            start_mode = blt_pkg::MODE_ARITH;
        end
        else if (c == blt_pkg::CH_QUOTE)
        begin
            start_mode = blt_pkg::MODE_STRING;
        end
        else
        begin
            start_emit = 1'b1;
            start_res  = '{tok_char: c, tok_kind: blt_pkg::KIND_SINGLE, tok_last: 1'b1,
                           line_end: 1'b0, unterminated: 1'b0};
        end

        case (scan_mode_reg)
            blt_pkg::MODE_STRING:
            begin
                res0  = held_res;
                n_res = 2'd1;
                if (c == blt_pkg::CH_QUOTE)
                begin
                    res1 = '{tok_char: c, tok_kind: blt_pkg::KIND_STRING, tok_last: 1'b1,
                             line_end: 1'b0, unterminated: 1'b0};
                    n_res          = 2'd2;
                    scan_mode_next = blt_pkg::MODE_IDLE;
                end
                else if (is_end)
                begin
                    res0.tok_last     = 1'b1;
                    res0.unterminated = 1'b1;
                    res1              = le_res;
                    n_res             = 2'd2;
                    scan_mode_next    = blt_pkg::MODE_IDLE;
                end
                else
                begin
                    held_char_next = c;
                end
            end
            blt_pkg::MODE_COMMENT:
            begin
                if (is_end || c == blt_pkg::CH_CR)
                begin
                    n_res          = 2'd1;
                    scan_mode_next = blt_pkg::MODE_IDLE;
                end
            end
            blt_pkg::MODE_IDENT, blt_pkg::MODE_NUMBER,
            blt_pkg::MODE_COMP, blt_pkg::MODE_ARITH:
            begin
                res0  = held_res;
                n_res = 2'd1;
                if (is_end)
                begin
                    res0.tok_last  = 1'b1;
                    res1           = le_res;
                    n_res          = 2'd2;
                    scan_mode_next = blt_pkg::MODE_IDLE;
                end
                else if (run_cont)
                begin
                    held_char_next = c;
                end
                else if (scan_mode_reg == blt_pkg::MODE_IDENT && c == blt_pkg::CH_DOLLAR)
                begin
                    res1 = '{tok_char: c, tok_kind: blt_pkg::KIND_IDENT, tok_last: 1'b1,
                             line_end: 1'b0, unterminated: 1'b0};
                    n_res          = 2'd2;
                    scan_mode_next = blt_pkg::MODE_IDLE;
                end
                else
                begin
                    // The run ends here and this character is scanned as if from idle.
                    res0.tok_last = 1'b1;
                    n_pre         = 2'd1;
                    to_idle_scan  = 1'b1;
                end
            end
            default:
            begin
                to_idle_scan = 1'b1;
            end
        endcase

        if (to_idle_scan)
        begin
            scan_mode_next = start_mode;
            held_char_next = c;
            if (start_emit)
            begin
                if (n_pre == 2'd0)
                begin
                    res0 = start_res;
                end
                else
                begin
                    res1 = start_res;
                end
                n_res = n_pre + 2'd1;
            end
            else
            begin
                n_res = n_pre;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mode_reg <= blt_pkg::MODE_IDLE;
            held_char_reg <= '0;
        end
        else if (accept)
        begin
            scan_mode_reg <= scan_mode_next;
            held_char_reg <= held_char_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && n_res != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && n_res == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    assign tokens.valid        = (count_reg != 3'd0);
    assign tokens.tok_char     = queue_reg[rd_ptr_reg].tok_char;
    assign tokens.tok_kind     = queue_reg[rd_ptr_reg].tok_kind;
    assign tokens.tok_last     = queue_reg[rd_ptr_reg].tok_last;
    assign tokens.line_end     = queue_reg[rd_ptr_reg].line_end;
    assign tokens.unterminated = queue_reg[rd_ptr_reg].unterminated;

endmodule

@@ dv/basic_line_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// basic_line_tokenizer_tb
// Drives source characters into the tokenizer and checks every token word
// and line end word against a predictor of the token scanner kept in the
// bench. Directed lines cover each token kind and the corner cases of line
// ends, comments, strings and high-bit characters. Random BASIC-like lines
// and raw noise follow, with random gaps on the input and random stalls on
// the output.
// ----------------------------------------------------------------------------
module basic_line_tokenizer_tb;

    logic clk;
    logic rst_n;

    blt_char_if char_bus ();
    blt_tok_if  tok_bus ();

    basic_line_tokenizer DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_bus),
        .tokens (tok_bus)
    );

    // Predictor state.
    blt_pkg::mode_t             lex_mode;
    logic [blt_pkg::CHAR_W-1:0] pending_ch;
    blt_pkg::result_t           words_due[$];

    int  mismatches;
    int  sent_count;
    bit  gaps_on;
    bit  stall_on;
    int  stall_left;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [4:0] char_class_of(input logic [blt_pkg::CHAR_W-1:0] ch);
        logic [6:0] c;
        c = ch[6:0];
        if ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) || c == 7'h5F)
            return blt_pkg::CL_ALPHA;
        if (c >= 7'h30 && c <= 7'h39)
            return blt_pkg::CL_DIGIT;
        if (c == 7'h08 || c == 7'h09 || c == 7'h0D || c == 7'h1A || c == 7'h1D ||
            c == 7'h20)
            return blt_pkg::CL_SPACE;
        if (c >= 7'h3C && c <= 7'h3E)
            return blt_pkg::CL_COMP;
        if (c == 7'h21 || c == 7'h25 || c == 7'h26 || c == 7'h2A || c == 7'h2B ||
            c == 7'h2D || c == 7'h2F)
            return blt_pkg::CL_ARITH;
        return 5'h00;
    endfunction

    task automatic push_word(input logic [blt_pkg::CHAR_W-1:0] ch,
                             input logic [blt_pkg::KIND_W-1:0] kind,
                             input logic last, input logic le, input logic unt);
        blt_pkg::result_t w;
        w.tok_char     = ch;
        w.tok_kind     = kind;
        w.tok_last     = last;
        w.line_end     = le;
        w.unterminated = unt;
        words_due.push_back(w);
    endtask

    task automatic push_line_end();
        // A line end word carries no character and reports kind zero.
        push_word(blt_pkg::CH_NUL, blt_pkg::KIND_IDENT, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic predict_words(input logic [blt_pkg::CHAR_W-1:0] c);
        logic [4:0] cls;
        logic       line_done;
        logic       try_start;
        logic       run_on;
        cls       = char_class_of(c);
        line_done = (c == blt_pkg::CH_LF) || (c == blt_pkg::CH_NUL);
        try_start = 1'b0;
        run_on    = 1'b0;
        case (lex_mode)
            blt_pkg::MODE_STRING:
            begin
                if (c == blt_pkg::CH_QUOTE)
                begin
                    push_word(pending_ch, blt_pkg::KIND_STRING, 1'b0, 1'b0, 1'b0);
                    push_word(c, blt_pkg::KIND_STRING, 1'b1, 1'b0, 1'b0);
                    lex_mode = blt_pkg::MODE_IDLE;
                end
                else if (line_done)
                begin
                    // The open string is closed on its last character and flagged.
                    push_word(pending_ch, blt_pkg::KIND_STRING, 1'b1, 1'b0, 1'b1);
                    push_line_end();
                    lex_mode = blt_pkg::MODE_IDLE;
                end
                else
                begin
                    push_word(pending_ch, blt_pkg::KIND_STRING, 1'b0, 1'b0, 1'b0);
                    pending_ch = c;
                end
            end
            blt_pkg::MODE_COMMENT:
            begin
                if (line_done || c == blt_pkg::CH_CR)
                begin
                    push_line_end();
                    lex_mode = blt_pkg::MODE_IDLE;
                end
            end
            blt_pkg::MODE_IDLE:
            begin
                try_start = 1'b1;
            end
            default:
            begin
                case (lex_mode)
                    blt_pkg::MODE_IDENT:
                        run_on = (cls & (blt_pkg::CL_ALPHA | blt_pkg::CL_DIGIT)) != 5'h00;
                    blt_pkg::MODE_NUMBER: run_on = (cls & blt_pkg::CL_DIGIT) != 5'h00;
                    blt_pkg::MODE_COMP:   run_on = (cls & blt_pkg::CL_COMP) != 5'h00;
                    default:              run_on = (cls & blt_pkg::CL_ARITH) != 5'h00;
                endcase
                if (line_done)
                begin
                    push_word(pending_ch, lex_mode, 1'b1, 1'b0, 1'b0);
                    push_line_end();
                    lex_mode = blt_pkg::MODE_IDLE;
                end
                else if (run_on)
                begin
                    push_word(pending_ch, lex_mode, 1'b0, 1'b0, 1'b0);
                    pending_ch = c;
                end
                else if (lex_mode == blt_pkg::MODE_IDENT && c == blt_pkg::CH_DOLLAR)
                begin
                    push_word(pending_ch, blt_pkg::KIND_IDENT, 1'b0, 1'b0, 1'b0);
                    push_word(c, blt_pkg::KIND_IDENT, 1'b1, 1'b0, 1'b0);
                    lex_mode = blt_pkg::MODE_IDLE;
                end
                else
                begin
                    // The run ends here and this character is scanned afresh.
                    push_word(pending_ch, lex_mode, 1'b1, 1'b0, 1'b0);
                    lex_mode  = blt_pkg::MODE_IDLE;
                    try_start = 1'b1;
                end
            end
        endcase

        if (try_start)
        begin
            if (line_done)
            begin
                push_line_end();
            end
            else if ((cls & blt_pkg::CL_SPACE) != 5'h00)
            begin
                // Whitespace between tokens is dropped.
            end
            else if (c == blt_pkg::CH_APOS)
            begin
                lex_mode = blt_pkg::MODE_COMMENT;
            end
            else if ((cls & blt_pkg::CL_ALPHA) != 5'h00)
            begin
                pending_ch = c;
                lex_mode   = blt_pkg::MODE_IDENT;
            end
            else if ((cls & blt_pkg::CL_DIGIT) != 5'h00)
            begin
                pending_ch = c;
                lex_mode   = blt_pkg::MODE_NUMBER;
            end
            else if ((cls & blt_pkg::CL_COMP) != 5'h00)
            begin
                pending_ch = c;
                lex_mode   = blt_pkg::MODE_COMP;
            end
            else if ((cls & blt_pkg::CL_ARITH) != 5'h00)
            begin
                pending_ch = c;
                lex_mode   = blt_pkg::MODE_ARITH;
            end
            else if (c == blt_pkg::CH_QUOTE)
            begin
                pending_ch = c;
                lex_mode   = blt_pkg::MODE_STRING;
            end
            else
            begin
                push_word(c, blt_pkg::KIND_SINGLE, 1'b1, 1'b0, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Handshake helpers
    // ------------------------------------------------------------------
    function automatic int pick_stretch();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_char(input logic [blt_pkg::CHAR_W-1:0] c);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? pick_stretch() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.in_char <= c;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        predict_words(c);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        char_bus.valid <= 1'b0;
    endtask

    task automatic wait_for_words();
        while (words_due.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls of mostly short and a few long stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            tok_bus.ready <= 1'b0;
            stall_left--;
        end
        else if (rst_n && stall_on && $urandom_range(0, 99) < 20)
        begin
            tok_bus.ready <= 1'b0;
            stall_left = pick_stretch() - 1;
        end
        else
        begin
            tok_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : word_check
        blt_pkg::result_t want;
        if (rst_n && tok_bus.valid && tok_bus.ready)
        begin
            if (words_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word char=%02h kind=%0d line_end=%0b",
                                          tok_bus.tok_char, tok_bus.tok_kind,
                                          tok_bus.line_end));
            end
            else
            begin
                want = words_due.pop_front();
                if (tok_bus.tok_char !== want.tok_char)
                    report_mismatch($sformatf("tok_char %02h, expected %02h",
                                              tok_bus.tok_char, want.tok_char));
                if (tok_bus.tok_kind !== want.tok_kind)
                    report_mismatch($sformatf("tok_kind %0d, expected %0d",
                                              tok_bus.tok_kind, want.tok_kind));
                if (tok_bus.tok_last !== want.tok_last)
                    report_mismatch($sformatf("tok_last %0b, expected %0b",
                                              tok_bus.tok_last, want.tok_last));
                if (tok_bus.line_end !== want.line_end)
                    report_mismatch($sformatf("line_end %0b, expected %0b",
                                              tok_bus.line_end, want.line_end));
                if (tok_bus.unterminated !== want.unterminated)
                    report_mismatch($sformatf("unterminated %0b, expected %0b",
                                              tok_bus.unterminated, want.unterminated));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [blt_pkg::CHAR_W-1:0] pick_of_class(input logic [4:0] mask);
        logic [blt_pkg::CHAR_W-1:0] c;
        c = 8'($urandom_range(0, 255));
        while ((char_class_of(c) & mask) == 5'h00)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [blt_pkg::CHAR_W-1:0] pick_string_char();
        logic [blt_pkg::CHAR_W-1:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == blt_pkg::CH_QUOTE || c == blt_pkg::CH_LF)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [blt_pkg::CHAR_W-1:0] pick_single();
        logic [blt_pkg::CHAR_W-1:0] c;
        c = 8'($urandom_range(1, 255));
        while (char_class_of(c) != 5'h00 || c == blt_pkg::CH_QUOTE ||
               c == blt_pkg::CH_APOS || c == blt_pkg::CH_LF)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic send_random_token();
        case ($urandom_range(0, 5))
            0:
            begin
                send_char(pick_of_class(blt_pkg::CL_ALPHA));
                repeat ($urandom_range(0, 5))
                    send_char(pick_of_class(blt_pkg::CL_ALPHA | blt_pkg::CL_DIGIT));
                if ($urandom_range(0, 2) == 0)
                    send_char(blt_pkg::CH_DOLLAR);
            end
            1: repeat ($urandom_range(1, 5)) send_char(pick_of_class(blt_pkg::CL_DIGIT));
            2: repeat ($urandom_range(1, 3)) send_char(pick_of_class(blt_pkg::CL_COMP));
            3: repeat ($urandom_range(1, 3)) send_char(pick_of_class(blt_pkg::CL_ARITH));
            4:
            begin
                send_char(blt_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 6)) send_char(pick_string_char());
                send_char(blt_pkg::CH_QUOTE);
            end
            default: send_char(pick_single());
        endcase
    endtask

    task automatic send_random_line();
        int r;
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 2)) send_char(pick_of_class(blt_pkg::CL_SPACE));
            send_random_token();
        end
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            send_char(blt_pkg::CH_LF);
        end
        else if (r < 80)
        begin
            send_char(blt_pkg::CH_NUL);
        end
        else if (r < 92)
        begin
            send_char(blt_pkg::CH_APOS);
            repeat ($urandom_range(0, 5)) send_char(pick_string_char());
            send_char(($urandom_range(0, 1) == 0) ? blt_pkg::CH_CR : blt_pkg::CH_LF);
        end
        else
        begin
            send_char(blt_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4)) send_char(pick_string_char());
            send_char(($urandom_range(0, 1) == 0) ? blt_pkg::CH_NUL : blt_pkg::CH_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_token_kinds();
        // Identifier with dollar, comparison, number and arithmetic runs,
        // then a string holding a carriage return and a high-bit quote.
        send_text("A_9$");
        send_char(8'h09);
        send_text("<>12+-");
        send_char(blt_pkg::CH_CR);
        send_text("\"H");
        send_char(blt_pkg::CH_CR);
        send_char(8'hA2);
        send_char(blt_pkg::CH_QUOTE);
        send_char(blt_pkg::CH_LF);
    endtask

    task automatic test_line_ends();
        send_text("'X");
        send_char(blt_pkg::CH_CR);
        send_text("\"Q");
        // Hold the input until the open string has drained its words.
        stop_sending();
        wait_for_words();
        send_char(blt_pkg::CH_NUL);
    endtask

    task automatic test_high_bit_chars();
        send_char(8'hC1);
        send_char(8'hFF);
        send_char(8'h8A);
        send_char(8'hA7);
        send_char(8'hB5);
        send_char(blt_pkg::CH_LF);
    endtask

    task automatic test_random_lines();
        int stop_at;
        stop_at = sent_count + 520;
        while (sent_count < stop_at)
        begin
            // Some lines run with no gaps and no stalls at all.
            gaps_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            send_random_line();
        end
        gaps_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    task automatic test_noise();
        repeat (100) send_char(8'($urandom_range(0, 255)));
        send_char(blt_pkg::CH_LF);
    endtask

    initial
    begin
        char_bus.valid   = 1'b0;
        char_bus.in_char = '0;
        tok_bus.ready    = 1'b0;
        rst_n            = 1'b0;
        lex_mode         = blt_pkg::MODE_IDLE;
        pending_ch       = '0;
        mismatches       = 0;
        sent_count       = 0;
        stall_left       = 0;
        gaps_on          = 1'b1;
        stall_on         = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_token_kinds();
        test_line_ends();
        test_high_bit_chars();
        test_random_lines();
        test_noise();

        stop_sending();
        wait_for_words();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && words_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d words outstanding", words_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
